FILE: rtl/core/fpr_pkg.sv
package fpr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h06;
  localparam logic [7:0] SYNC_SECOND = 8'h85;

  localparam int unsigned CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_FRAME_SIZE_ADDR = 2'd0;
  localparam logic [7:0] FRAME_SIZE_RESET = 8'd1;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_LEN,
    PH_DATA,
    PH_CHECK
  } phase_t;

  typedef enum logic [3:0] {
    ST_HUNT     = 4'd0,
    ST_SYNC     = 4'd1,
    ST_LEN_OK   = 4'd2,
    ST_LEN_BAD  = 4'd3,
    ST_STORED   = 4'd4,
    ST_GOOD     = 4'd5,
    ST_BAD_CS   = 4'd6,
    ST_READ_OK  = 4'd7,
    ST_READ_REJ = 4'd8
  } status_t;

  // Per-item control from the deframer to the store and the pipeline.
  typedef struct packed {
    logic       we;
    logic       wbank;
    logic [7:0] widx;
    logic       re;
    logic       rbank;
    logic       rd_ok;
    status_t    status;
  } store_ctl_t;

endpackage

FILE: rtl/core/fpr_deframer.sv
module fpr_deframer #(
  parameter int unsigned BANK_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   opcode,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             read_index,
  input  logic [7:0]             frame_size,
  output fpr_pkg::store_ctl_t    ctl
);

  localparam logic [8:0] DEPTH_W = 9'(BANK_DEPTH);

  fpr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       bank_r, bank_nxt;
  logic       has_frame_r, has_frame_nxt;

  logic [8:0] fs9;
  logic [8:0] limit9;
  logic [7:0] idx_inc;
  logic       len_ok;

  assign fs9     = {1'b0, frame_size};
  assign limit9  = (fs9 < DEPTH_W) ? fs9 : DEPTH_W;
  assign idx_inc = idx_r + 8'd1;
  assign len_ok  = (rx_byte == frame_size) && (rx_byte != 8'd0) &&
                   ({1'b0, rx_byte} <= DEPTH_W);

  // Next state
  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    bank_nxt      = bank_r;
    has_frame_nxt = has_frame_r;
    if (accept && !opcode) begin
      unique case (phase_r)
        fpr_pkg::PH_HUNT: begin
          if (rx_byte == fpr_pkg::SYNC_FIRST) phase_nxt = fpr_pkg::PH_SYNC2;
        end
        fpr_pkg::PH_SYNC2: begin
          if (rx_byte == fpr_pkg::SYNC_SECOND) begin
            phase_nxt = fpr_pkg::PH_LEN;
          end else begin
            phase_nxt = fpr_pkg::PH_HUNT;
            idx_nxt   = 8'd0;
            acc_nxt   = 8'd0;
          end
        end
        fpr_pkg::PH_LEN: begin
          if (len_ok) begin
            phase_nxt = fpr_pkg::PH_DATA;
            idx_nxt   = 8'd0;
            acc_nxt   = rx_byte;
          end else begin
            phase_nxt = fpr_pkg::PH_HUNT;
            idx_nxt   = 8'd0;
            acc_nxt   = 8'd0;
          end
        end
        fpr_pkg::PH_DATA: begin
          acc_nxt = acc_r ^ rx_byte;
          idx_nxt = idx_inc;
          // end of payload at the current size, clipped to the bank
          if (idx_inc == 8'd0 || {1'b0, idx_inc} >= limit9) phase_nxt = fpr_pkg::PH_CHECK;
        end
        fpr_pkg::PH_CHECK: begin
          if (rx_byte == acc_r) begin
            bank_nxt      = ~bank_r;
            has_frame_nxt = 1'b1;
          end
          phase_nxt = fpr_pkg::PH_HUNT;
          idx_nxt   = 8'd0;
          acc_nxt   = 8'd0;
        end
        default: begin
          phase_nxt = fpr_pkg::PH_HUNT;
          idx_nxt   = 8'd0;
          acc_nxt   = 8'd0;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    ctl        = '0;
    ctl.wbank  = ~bank_r;
    ctl.widx   = idx_r;
    ctl.rbank  = bank_r;
    ctl.re     = accept && opcode;
    ctl.status = fpr_pkg::ST_HUNT;
    if (opcode) begin
      ctl.rd_ok  = has_frame_r && (read_index < frame_size) &&
                   ({1'b0, read_index} < DEPTH_W);
      ctl.status = ctl.rd_ok ? fpr_pkg::ST_READ_OK : fpr_pkg::ST_READ_REJ;
    end else begin
      unique case (phase_r)
        fpr_pkg::PH_HUNT: begin
          ctl.status = (rx_byte == fpr_pkg::SYNC_FIRST) ? fpr_pkg::ST_SYNC : fpr_pkg::ST_HUNT;
        end
        fpr_pkg::PH_SYNC2: begin
          ctl.status = (rx_byte == fpr_pkg::SYNC_SECOND) ? fpr_pkg::ST_SYNC : fpr_pkg::ST_HUNT;
        end
        fpr_pkg::PH_LEN: begin
          ctl.status = len_ok ? fpr_pkg::ST_LEN_OK : fpr_pkg::ST_LEN_BAD;
        end
        fpr_pkg::PH_DATA: begin
          ctl.we     = accept && ({1'b0, idx_r} < DEPTH_W);
          ctl.status = fpr_pkg::ST_STORED;
        end
        fpr_pkg::PH_CHECK: begin
          ctl.status = (rx_byte == acc_r) ? fpr_pkg::ST_GOOD : fpr_pkg::ST_BAD_CS;
        end
        default: begin
          ctl.status = fpr_pkg::ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fpr_pkg::PH_HUNT;
      idx_r       <= 8'd0;
      acc_r       <= 8'd0;
      bank_r      <= 1'b0;
      has_frame_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      bank_r      <= bank_nxt;
      has_frame_r <= has_frame_nxt;
    end
  end

  a_idx_in_bank: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == fpr_pkg::PH_DATA |-> {1'b0, idx_r} < DEPTH_W)
    else $error("payload index beyond bank");

  a_has_frame_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    has_frame_r |=> has_frame_r)
    else $error("committed frame lost");

  a_bank_flip_on_good: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && ctl.status == fpr_pkg::ST_GOOD) |=> $stable(bank_r))
    else $error("bank flipped without a good frame");

  a_write_staging_only: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.we |-> (phase_r == fpr_pkg::PH_DATA && ctl.wbank != bank_r && !opcode))
    else $error("write outside staging bank");

endmodule

FILE: rtl/core/framed_packet_receiver_core.sv
// Path: an accepted item passes through the store read register and s1 stage,
//   then through the output register.
// Throughput: one item per cycle unless out_stall holds the output; the
//   frame store takes one write and one read per cycle; read data is registered.
// Reset: synchronous, active low; clears the deframer, bank select, frame flag
//   and pipeline valids, sets frame_size to 1; the frame store is not cleared.
module framed_packet_receiver_core #(
  parameter int unsigned BANK_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [7:0]                  in_rx_byte,
  input  logic [7:0]                  in_read_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  out_status,
  output logic [7:0]                  out_read_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpr_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned AW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned MEM_DEPTH = 2 * (2 ** AW);

  logic [7:0] frame_size_r;
  logic       in_accept;
  logic       s1_adv;
  fpr_pkg::store_ctl_t ctl;

  logic             s1_valid_r;
  fpr_pkg::status_t s1_status_r;
  logic             s1_rd_ok_r;
  logic [7:0]       mem_rdata_r;

  logic             out_valid_r;
  fpr_pkg::status_t out_status_r;
  logic [7:0]       out_read_data_r;

  logic [7:0] frame_store [MEM_DEPTH];
  logic [AW:0] waddr;
  logic [AW:0] raddr;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == fpr_pkg::REG_FRAME_SIZE_ADDR) ? {24'd0, frame_size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= fpr_pkg::FRAME_SIZE_RESET;
    end else if (psel && penable && pwrite && paddr == fpr_pkg::REG_FRAME_SIZE_ADDR) begin
      frame_size_r <= pwdata[7:0];
    end
  end

  // Handshake: hold input while the read stage cannot drain
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  fpr_deframer #(
    .BANK_DEPTH(BANK_DEPTH)
  ) u_deframer (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .opcode     (in_opcode),
    .rx_byte    (in_rx_byte),
    .read_index (in_read_index),
    .frame_size (frame_size_r),
    .ctl        (ctl)
  );

  assign waddr = {ctl.wbank, ctl.widx[AW-1:0]};
  assign raddr = {ctl.rbank, in_read_index[AW-1:0]};

  // Frame store: staging writes and committed reads never hit the same bank
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      frame_store[waddr] <= in_rx_byte;
    end
    if (ctl.re) begin
      mem_rdata_r <= frame_store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_status_r <= ctl.status;
      s1_rd_ok_r  <= ctl.rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_status_r    <= s1_status_r;
      out_read_data_r <= s1_rd_ok_r ? mem_rdata_r : 8'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_read_data_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with empty pipeline");

  a_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_read_data_r != 8'd0) |-> out_status_r == fpr_pkg::ST_READ_OK)
    else $error("read data on non-read result");

  a_item_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> out_valid_r)
    else $error("item lost between stages");

endmodule
